/* hdl/size_class_bitmap_pool_allocator_macros.svh */
// Assertion macros shared by the allocator RTL.
`ifndef SIZE_CLASS_BITMAP_POOL_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BITMAP_POOL_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define SCBPA_CHECK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// Checked property, live through reset.
`define SCBPA_CHECK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCBPA_CHECK(label, clk, rstn, prop, msg)
`define SCBPA_CHECK_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* hdl/scbpa_pkg.sv */
// Shared types, codes and defaults for the size-class pool allocator.
package scbpa_pkg;

  localparam int SMALL_SLOTS_DEF  = 32;
  localparam int SMALL_BYTES_DEF  = 40;
  localparam int MEDIUM_SLOTS_DEF = 16;
  localparam int MEDIUM_BYTES_DEF = 80;
  localparam int LARGE_SLOTS_DEF  = 16;
  localparam int LARGE_BYTES_DEF  = 96;

  localparam int SLOT_W  = 5;
  localparam int USED_W  = 6;
  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 16;
  localparam int TOTAL_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [ADDR_W-1:0] SMALL_BASE_RST  = 32'd0;
  localparam logic [ADDR_W-1:0] LARGE_BASE_RST  = 32'd1280;
  localparam logic [ADDR_W-1:0] MEDIUM_BASE_RST = 32'd2816;

  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_BASE = 2'd2;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_RELEASE = 2'd2;
  localparam logic [1:0] ST_FOREIGN = 2'd3;

  localparam logic [1:0] POOL_SMALL  = 2'd0;
  localparam logic [1:0] POOL_MEDIUM = 2'd1;
  localparam logic [1:0] POOL_LARGE  = 2'd2;
  localparam logic [1:0] POOL_NONE   = 2'd3;

  typedef struct packed {
    logic alloc;
    logic release_slot;
  } pool_cmd_t;

  typedef struct packed {
    logic               free_any;
    logic [SLOT_W-1:0]  free_slot;
    logic [ADDR_W-1:0]  alloc_addr;
    logic               hit;
    logic [SLOT_W-1:0]  hit_slot;
    logic               hit_busy;
    logic [USED_W-1:0]  used;
    logic [TOTAL_W-1:0] total;
  } pool_stat_t;

endpackage

/* hdl/scbpa_in_if.sv */
// Request channel: valid/ready plus the request fields.
interface scbpa_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] request_size;
  logic [31:0] release_address;

  modport source (output valid, kind, request_size, release_address, input ready);
  modport sink   (input valid, kind, request_size, release_address, output ready);
endinterface

/* hdl/scbpa_out_if.sv */
// Result channel: valid/ready plus the result fields.
interface scbpa_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  pool_id;
  logic [4:0]  slot;
  logic [31:0] slot_address;
  logic [5:0]  small_used;
  logic [4:0]  medium_used;
  logic [4:0]  large_used;
  logic [31:0] small_total;
  logic [31:0] medium_total;
  logic [31:0] large_total;

  modport source (output valid, status, pool_id, slot, slot_address, small_used,
                  medium_used, large_used, small_total, medium_total, large_total,
                  input ready);
  modport sink   (input valid, status, pool_id, slot, slot_address, small_used,
                  medium_used, large_used, small_total, medium_total, large_total,
                  output ready);
endinterface

/* hdl/scbpa_pool.sv */
// One slot pool: free mask, lowest-free encoder, address decode and counters.
`include "size_class_bitmap_pool_allocator_macros.svh"
module scbpa_pool
  import scbpa_pkg::*;
#(
  parameter int SLOTS = SMALL_SLOTS_DEF,
  parameter int BYTES = SMALL_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] base,
  input  logic [ADDR_W-1:0] addr,
  input  pool_cmd_t         cmd,
  output pool_stat_t        stat
);

  localparam int SPAN  = SLOTS * BYTES;
  localparam int OFF_W = $clog2(SPAN + 1);
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0]   mask_r;
  logic [USED_W-1:0]  used_r;
  logic [TOTAL_W-1:0] total_r;

  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] hit_slot;
  logic [ADDR_W:0]   diff;
  logic [OFF_W-1:0]  off;
  logic [OFF_W-1:0]  slot_off;
  logic              in_range;

  // lowest set bit of the free mask
  always_comb begin
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) free_slot = SLOT_W'(i);
    end
  end

  assign slot_off = OFF_W'(free_slot) * OFF_W'(BYTES);

  assign diff     = {1'b0, addr} - {1'b0, base};
  assign in_range = !diff[ADDR_W] && (diff[ADDR_W-1:0] < ADDR_W'(SPAN));
  assign off      = diff[OFF_W-1:0];

  // slot = highest slot boundary at or below the offset
  always_comb begin
    hit_slot = '0;
    for (int j = 1; j < SLOTS; j++) begin
      if (off >= OFF_W'(j * BYTES)) hit_slot = SLOT_W'(j);
    end
  end

  always_comb begin
    stat.free_any   = |mask_r;
    stat.free_slot  = free_slot;
    stat.alloc_addr = base + ADDR_W'(slot_off);
    stat.hit        = in_range;
    stat.hit_slot   = hit_slot;
    stat.hit_busy   = !mask_r[hit_slot[IDX_W-1:0]];
    stat.used       = used_r;
    stat.total      = total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '1;
      used_r  <= '0;
      total_r <= '0;
    end else if (cmd.alloc) begin
      mask_r[free_slot[IDX_W-1:0]] <= 1'b0;
      used_r  <= used_r + USED_W'(1);
      total_r <= total_r + TOTAL_W'(1);
    end else if (cmd.release_slot) begin
      mask_r[hit_slot[IDX_W-1:0]] <= 1'b1;
      if (stat.hit_busy) used_r <= used_r - USED_W'(1);
    end
  end

  `SCBPA_CHECK(a_alloc_needs_free, clk, rst_n, cmd.alloc |-> stat.free_any, "alloc from full pool")
  `SCBPA_CHECK(a_one_cmd, clk, rst_n, !(cmd.alloc && cmd.release_slot), "alloc and release together")
  `SCBPA_CHECK(a_used_bound, clk, rst_n, used_r <= USED_W'(SLOTS), "used count past pool size")
  `SCBPA_CHECK(a_alloc_counts, clk, rst_n, cmd.alloc |=> used_r == $past(used_r) + USED_W'(1), "used count missed alloc")

endmodule

/* hdl/size_class_bitmap_pool_allocator.sv */
// Requests are decoded in one pass between the input register and the result register.
// Throughput: one request per cycle while results are taken (out_rsp.ready high).
// The critical path is the release address decode feeding the free-mask and counter update.
// Reset (rst_n low, synchronous): all slots free, counters zero, base registers to defaults.
// No clearing pass: requests are taken as soon as reset is released.
`include "size_class_bitmap_pool_allocator_macros.svh"
module size_class_bitmap_pool_allocator
  import scbpa_pkg::*;
#(
  parameter int SMALL_SLOTS  = SMALL_SLOTS_DEF,
  parameter int SMALL_BYTES  = SMALL_BYTES_DEF,
  parameter int MEDIUM_SLOTS = MEDIUM_SLOTS_DEF,
  parameter int MEDIUM_BYTES = MEDIUM_BYTES_DEF,
  parameter int LARGE_SLOTS  = LARGE_SLOTS_DEF,
  parameter int LARGE_BYTES  = LARGE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  scbpa_in_if.sink             in_req,
  scbpa_out_if.source          out_rsp
);

  logic [ADDR_W-1:0] small_base_r, large_base_r, medium_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_base_r  <= SMALL_BASE_RST;
      large_base_r  <= LARGE_BASE_RST;
      medium_base_r <= MEDIUM_BASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SMALL_BASE:  small_base_r  <= cfg_data;
        CFG_LARGE_BASE:  large_base_r  <= cfg_data;
        CFG_MEDIUM_BASE: medium_base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic              s1_valid_r;
  logic              s1_kind_r;
  logic [SIZE_W-1:0] s1_size_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              out_valid_r;
  logic              out_free, adv, in_take;

  assign out_free     = !out_valid_r || out_rsp.ready;
  assign adv          = s1_valid_r && out_free;
  assign in_req.ready = !s1_valid_r || out_free;
  assign in_take      = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind_r <= in_req.kind;
      s1_size_r <= in_req.request_size;
      s1_addr_r <= in_req.release_address;
    end
  end

  pool_cmd_t  cmd_s, cmd_m, cmd_l;
  pool_stat_t st_s, st_m, st_l;

  scbpa_pool #(.SLOTS(SMALL_SLOTS), .BYTES(SMALL_BYTES)) u_small (
    .clk(clk), .rst_n(rst_n), .base(small_base_r), .addr(s1_addr_r), .cmd(cmd_s), .stat(st_s)
  );
  scbpa_pool #(.SLOTS(MEDIUM_SLOTS), .BYTES(MEDIUM_BYTES)) u_medium (
    .clk(clk), .rst_n(rst_n), .base(medium_base_r), .addr(s1_addr_r), .cmd(cmd_m), .stat(st_m)
  );
  scbpa_pool #(.SLOTS(LARGE_SLOTS), .BYTES(LARGE_BYTES)) u_large (
    .clk(clk), .rst_n(rst_n), .base(large_base_r), .addr(s1_addr_r), .cmd(cmd_l), .stat(st_l)
  );

  logic       is_alloc;
  logic [1:0] cls;

  assign is_alloc = (s1_kind_r == KIND_ALLOC);

  always_comb begin
    if (s1_size_r <= SIZE_W'(SMALL_BYTES))       cls = POOL_SMALL;
    else if (s1_size_r <= SIZE_W'(MEDIUM_BYTES)) cls = POOL_MEDIUM;
    else if (s1_size_r <= SIZE_W'(LARGE_BYTES))  cls = POOL_LARGE;
    else                                         cls = POOL_NONE;
  end

  // release decode priority: small, large, medium
  always_comb begin
    cmd_s.alloc        = adv && is_alloc && (cls == POOL_SMALL) && st_s.free_any;
    cmd_m.alloc        = adv && is_alloc && (cls == POOL_MEDIUM) && st_m.free_any;
    cmd_l.alloc        = adv && is_alloc && (cls == POOL_LARGE) && st_l.free_any;
    cmd_s.release_slot = adv && !is_alloc && st_s.hit;
    cmd_l.release_slot = adv && !is_alloc && !st_s.hit && st_l.hit;
    cmd_m.release_slot = adv && !is_alloc && !st_s.hit && !st_l.hit && st_m.hit;
  end

  logic [1:0]         status_nxt, pool_nxt;
  logic [SLOT_W-1:0]  slot_nxt;
  logic [ADDR_W-1:0]  saddr_nxt;
  logic [USED_W-1:0]  s_used_nxt, m_used_nxt, l_used_nxt;
  logic [TOTAL_W-1:0] s_total_nxt, m_total_nxt, l_total_nxt;

  always_comb begin
    status_nxt = ST_MISS;
    pool_nxt   = POOL_NONE;
    slot_nxt   = '0;
    saddr_nxt  = '0;
    if (is_alloc) begin
      pool_nxt = cls;
      case (cls)
        POOL_SMALL: if (st_s.free_any) begin
          status_nxt = ST_ALLOC;
          slot_nxt   = st_s.free_slot;
          saddr_nxt  = st_s.alloc_addr;
        end
        POOL_MEDIUM: if (st_m.free_any) begin
          status_nxt = ST_ALLOC;
          slot_nxt   = st_m.free_slot;
          saddr_nxt  = st_m.alloc_addr;
        end
        POOL_LARGE: if (st_l.free_any) begin
          status_nxt = ST_ALLOC;
          slot_nxt   = st_l.free_slot;
          saddr_nxt  = st_l.alloc_addr;
        end
        default: ;
      endcase
    end else if (st_s.hit) begin
      status_nxt = ST_RELEASE;
      pool_nxt   = POOL_SMALL;
      slot_nxt   = st_s.hit_slot;
    end else if (st_l.hit) begin
      status_nxt = ST_RELEASE;
      pool_nxt   = POOL_LARGE;
      slot_nxt   = st_l.hit_slot;
    end else if (st_m.hit) begin
      status_nxt = ST_RELEASE;
      pool_nxt   = POOL_MEDIUM;
      slot_nxt   = st_m.hit_slot;
    end else begin
      status_nxt = ST_FOREIGN;
    end
  end

  // counts after this request
  assign s_used_nxt = st_s.used + USED_W'(cmd_s.alloc)
                    - USED_W'(cmd_s.release_slot && st_s.hit_busy);
  assign m_used_nxt = st_m.used + USED_W'(cmd_m.alloc)
                    - USED_W'(cmd_m.release_slot && st_m.hit_busy);
  assign l_used_nxt = st_l.used + USED_W'(cmd_l.alloc)
                    - USED_W'(cmd_l.release_slot && st_l.hit_busy);
  assign s_total_nxt = st_s.total + TOTAL_W'(cmd_s.alloc);
  assign m_total_nxt = st_m.total + TOTAL_W'(cmd_m.alloc);
  assign l_total_nxt = st_l.total + TOTAL_W'(cmd_l.alloc);

  // result register
  logic [1:0]         status_r, pool_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [ADDR_W-1:0]  saddr_r;
  logic [USED_W-1:0]  s_used_r, m_used_r, l_used_r;
  logic [TOTAL_W-1:0] s_total_r, m_total_r, l_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r  <= status_nxt;
      pool_r    <= pool_nxt;
      slot_r    <= slot_nxt;
      saddr_r   <= saddr_nxt;
      s_used_r  <= s_used_nxt;
      m_used_r  <= m_used_nxt;
      l_used_r  <= l_used_nxt;
      s_total_r <= s_total_nxt;
      m_total_r <= m_total_nxt;
      l_total_r <= l_total_nxt;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = status_r;
  assign out_rsp.pool_id      = pool_r;
  assign out_rsp.slot         = slot_r;
  assign out_rsp.slot_address = saddr_r;
  assign out_rsp.small_used   = s_used_r;
  assign out_rsp.medium_used  = m_used_r[4:0];
  assign out_rsp.large_used   = l_used_r[4:0];
  assign out_rsp.small_total  = s_total_r;
  assign out_rsp.medium_total = m_total_r;
  assign out_rsp.large_total  = l_total_r;

  `SCBPA_CHECK(a_one_pool_touched, clk, rst_n, $onehot0({cmd_s.alloc, cmd_m.alloc, cmd_l.alloc, cmd_s.release_slot, cmd_m.release_slot, cmd_l.release_slot}), "several pools updated by one request")
  `SCBPA_CHECK(a_stage_holds, clk, rst_n, (s1_valid_r && !out_free) |=> s1_valid_r, "pending request dropped")
  `SCBPA_CHECK(a_alloc_has_pool, clk, rst_n, (out_valid_r && status_r == ST_ALLOC) |-> (pool_r != POOL_NONE), "allocation without a pool")
  `SCBPA_CHECK_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule
